// ===== rtl/tsc_pkg.sv =====
package tsc_pkg;

    // Default width of the usable part of a section size field
    localparam int SIZE_BITS_DEF = 32;

    // Reflected CRC-32
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    // Section magic words, first file byte in the top byte
    localparam logic [31:0] MAGIC_HEADER = 32'h4B464814;
    localparam logic [31:0] MAGIC_SOUND  = 32'h4B534E01;
    localparam logic [31:0] MAGIC_FRAMES = 32'h4B4D4302;
    localparam logic [31:0] MAGIC_INFO   = 32'h4B4D4905;
    localparam logic [31:0] MAGIC_THUMB  = 32'h4B544E02;

    // Section layout, offsets from the section start
    localparam logic [5:0] SOUND_CRC_AT = 6'h20;
    localparam logic [5:0] OTHER_CRC_AT = 6'h08;
    localparam logic [5:0] SOUND_MIN    = 6'h1C;
    localparam logic [5:0] OTHER_MIN    = 6'h04;
    localparam logic [5:0] INFO_MIN     = 6'h00;
    localparam logic [5:0] POS_CAP      = 6'h24;
    localparam logic [5:0] POS_SIZE     = 6'd4;
    localparam logic [5:0] POS_LAST_SZ  = 6'd7;
    localparam logic [5:0] POS_BODY     = 6'd8;
    localparam logic [5:0] POS_LAST_MAG = 6'd3;

    typedef enum logic [2:0] {
        PH_HEAD,
        PH_WORD,
        PH_SIZE,
        PH_BODY,
        PH_SKIP,
        PH_IGNORE
    } phase_t;

    typedef enum logic [2:0] {
        KIND_HEADER,
        KIND_SOUND,
        KIND_FRAMES,
        KIND_INFO,
        KIND_THUMB,
        KIND_UNKNOWN
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_BAD,
        ST_UNCHECKED,
        ST_MAGIC,
        ST_TRUNC,
        ST_SMALL
    } status_t;

    typedef struct packed {
        kind_t       kind;
        status_t     status;
        logic [31:0] start;
        logic [31:0] comp;
        logic [31:0] stored;
        logic        last;
    } result_t;

endpackage

// ===== rtl/tagged_section_crc_verifier_core.sv =====
// A result passes two registers: the byte that causes it is transferred into the input register,
// and the result it causes is then offered from the result register.
// Throughput: one byte per cycle; the bytewise CRC XOR tree and the section counters
// update in a single stage. Output stall holds the input side once the input register fills.
// Reset (rst_n, asynchronous, active low) clears all parser state; the block then expects
// the file header magic of a new file. The same happens after the end-of-file byte.
module tagged_section_crc_verifier_core #(
    parameter int SIZE_BITS = tsc_pkg::SIZE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        end_of_file,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  section_kind,
    output logic [2:0]  status,
    output logic [31:0] section_start,
    output logic [31:0] computed_crc,
    output logic [31:0] stored_crc,
    output logic        last_result
);
    import tsc_pkg::*;

    logic       a_valid_reg, a_valid_next;
    logic [7:0] a_byte_reg;
    logic       a_eof_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    res_reg;
    result_t    res;
    logic       emit;
    logic       step;
    logic       accept;

    // Input stage advances when the result slot is free or being drained
    assign step     = a_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = a_valid_reg && !step;
    assign accept   = in_valid && !in_stall;

    assign a_valid_next   = accept ? 1'b1 : (step ? 1'b0 : a_valid_reg);
    assign out_valid_next = (step && emit) ? 1'b1 :
                            (out_stall ? out_valid_reg : 1'b0);

    tsc_parser #(
        .SIZE_BITS (SIZE_BITS)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .data_byte   (a_byte_reg),
        .end_of_file (a_eof_reg),
        .emit        (emit),
        .res         (res)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_byte_reg <= data_byte;
            a_eof_reg  <= end_of_file;
        end
        if (step && emit)
        begin
            res_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign section_kind  = res_reg.kind;
    assign status        = res_reg.status;
    assign section_start = res_reg.start;
    assign computed_crc  = res_reg.comp;
    assign stored_crc    = res_reg.stored;
    assign last_result   = res_reg.last;

endmodule

// ===== rtl/tsc_crc_byte.sv =====
module tsc_crc_byte (
    input  logic [31:0] crc_in,
    input  logic [7:0]  data,
    output logic [31:0] crc_out
);
    import tsc_pkg::*;

    logic [31:0] acc;

    // Eight bit steps of the reflected CRC, flattened into an XOR tree
    always_comb
    begin
        acc = crc_in ^ {24'd0, data};
        for (int i = 0; i < 8; i++)
        begin
            acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
        end
        crc_out = acc;
    end

endmodule

// ===== rtl/tsc_parser.sv =====
module tsc_parser #(
    parameter int SIZE_BITS = tsc_pkg::SIZE_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       data_byte,
    input  logic             end_of_file,
    output logic             emit,
    output tsc_pkg::result_t res
);
    import tsc_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic [31:0]            file_pos_reg, file_pos_next;
    logic [5:0]             pos_reg, pos_next;
    logic [SIZE_BITS-1:0]   len_reg, len_next;
    kind_t                  kind_reg, kind_next;
    logic [23:0]            magic_reg, magic_next;
    logic [31:0]            exp_reg, exp_next;
    logic [31:0]            run_reg, run_next;
    logic [31:0]            start_reg, start_next;

    logic                   in_magic;
    logic [31:0]            start_cur;
    logic [23:0]            magic_base;
    logic [31:0]            word;
    logic                   word_known;
    kind_t                  word_kind;
    logic [SIZE_BITS-1:0]   byte_ext;
    logic [SIZE_BITS-1:0]   len_acc;
    logic [SIZE_BITS-1:0]   len_dec;
    logic [5:0]             min_size;
    logic                   size_done;
    logic                   size_small;
    logic                   size_zero;
    logic [5:0]             crc_at;
    logic                   body_last;
    logic [31:0]            crc_upd;

    // Shared decode
    assign in_magic   = (phase_reg == PH_HEAD) || (phase_reg == PH_WORD);
    assign start_cur  = (in_magic && pos_reg == 6'd0) ? file_pos_reg : start_reg;
    assign magic_base = (pos_reg == 6'd0) ? 24'd0 : magic_reg;
    assign word       = {magic_reg, data_byte};

    always_comb
    begin
        word_known = 1'b1;
        case (word)
            MAGIC_SOUND:  word_kind = KIND_SOUND;
            MAGIC_FRAMES: word_kind = KIND_FRAMES;
            MAGIC_INFO:   word_kind = KIND_INFO;
            MAGIC_THUMB:  word_kind = KIND_THUMB;
            default:
            begin
                word_kind  = KIND_UNKNOWN;
                word_known = 1'b0;
            end
        endcase
    end

    // Size field assembly, little endian, upper bits dropped
    assign byte_ext   = SIZE_BITS'(data_byte);
    assign len_acc    = len_reg | (byte_ext << {pos_reg[1:0], 3'b000});
    assign min_size   = (kind_reg == KIND_SOUND) ? SOUND_MIN :
                        ((kind_reg == KIND_INFO) ? INFO_MIN : OTHER_MIN);
    assign size_done  = (pos_reg == POS_LAST_SZ);
    assign size_small = len_acc < SIZE_BITS'(min_size);
    assign size_zero  = (len_acc == '0);

    // Body bookkeeping
    assign crc_at    = (kind_reg == KIND_SOUND) ? SOUND_CRC_AT : OTHER_CRC_AT;
    assign len_dec   = len_reg - SIZE_BITS'(1);
    assign body_last = (len_dec == '0);

    tsc_crc_byte u_crc (
        .crc_in  (run_reg),
        .data    (data_byte),
        .crc_out (crc_upd)
    );

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (step)
        begin
            if (end_of_file)
            begin
                phase_next = PH_HEAD;
            end
            else
            begin
                case (phase_reg)
                    PH_HEAD:
                    begin
                        if (pos_reg == POS_LAST_MAG)
                        begin
                            phase_next = (word == MAGIC_HEADER) ? PH_SIZE : PH_IGNORE;
                        end
                    end
                    PH_WORD:
                    begin
                        if (pos_reg == POS_LAST_MAG && word_known)
                        begin
                            phase_next = PH_SIZE;
                        end
                    end
                    PH_SIZE:
                    begin
                        if (size_done)
                        begin
                            if (size_small)
                            begin
                                phase_next = size_zero ? PH_WORD : PH_SKIP;
                            end
                            else if (size_zero)
                            begin
                                phase_next = PH_WORD;
                            end
                            else
                            begin
                                phase_next = PH_BODY;
                            end
                        end
                    end
                    PH_BODY:
                    begin
                        if (body_last)
                        begin
                            phase_next = PH_WORD;
                        end
                    end
                    PH_SKIP:
                    begin
                        if (body_last)
                        begin
                            phase_next = PH_WORD;
                        end
                    end
                    PH_IGNORE:
                    begin
                        phase_next = PH_IGNORE;
                    end
                    default:
                    begin
                        phase_next = PH_HEAD;
                    end
                endcase
            end
        end
    end

    // Datapath updates and result
    always_comb
    begin
        file_pos_next = file_pos_reg;
        pos_next      = pos_reg;
        len_next      = len_reg;
        kind_next     = kind_reg;
        magic_next    = magic_reg;
        exp_next      = exp_reg;
        run_next      = run_reg;
        start_next    = start_reg;
        emit          = 1'b0;
        res.kind      = kind_reg;
        res.status    = ST_TRUNC;
        res.start     = start_cur;
        res.comp      = 32'd0;
        res.stored    = 32'd0;
        res.last      = end_of_file;

        if (step)
        begin
            file_pos_next = file_pos_reg + 32'd1;
            case (phase_reg)
                PH_HEAD, PH_WORD:
                begin
                    start_next = start_cur;
                    if (pos_reg != POS_LAST_MAG)
                    begin
                        magic_next = {magic_base[15:0], data_byte};
                        pos_next   = pos_reg + 6'd1;
                        if (end_of_file)
                        begin
                            emit     = 1'b1;
                            res.kind = (phase_reg == PH_HEAD) ? KIND_HEADER : KIND_UNKNOWN;
                        end
                    end
                    else if ((phase_reg == PH_HEAD && word == MAGIC_HEADER) ||
                             (phase_reg == PH_WORD && word_known))
                    begin
                        // Known magic opens a section
                        kind_next = (phase_reg == PH_HEAD) ? KIND_HEADER : word_kind;
                        pos_next  = POS_SIZE;
                        len_next  = '0;
                        exp_next  = 32'd0;
                        run_next  = CRC_INIT;
                        if (end_of_file)
                        begin
                            emit     = 1'b1;
                            res.kind = kind_next;
                        end
                    end
                    else if (phase_reg == PH_HEAD)
                    begin
                        emit       = 1'b1;
                        res.kind   = KIND_HEADER;
                        res.status = ST_MAGIC;
                    end
                    else
                    begin
                        emit       = 1'b1;
                        res.kind   = KIND_UNKNOWN;
                        res.status = ST_UNCHECKED;
                        pos_next   = 6'd0;
                        magic_next = 24'd0;
                    end
                end
                PH_SIZE:
                begin
                    len_next = len_acc;
                    pos_next = pos_reg + 6'd1;
                    if (size_done)
                    begin
                        pos_next = POS_BODY;
                        if (size_small)
                        begin
                            emit       = 1'b1;
                            res.status = ST_SMALL;
                            if (size_zero)
                            begin
                                pos_next   = 6'd0;
                                magic_next = 24'd0;
                            end
                        end
                        else if (size_zero)
                        begin
                            emit       = 1'b1;
                            res.status = ST_UNCHECKED;
                            pos_next   = 6'd0;
                            magic_next = 24'd0;
                        end
                        else if (end_of_file)
                        begin
                            emit = 1'b1;
                        end
                    end
                    else if (end_of_file)
                    begin
                        emit = 1'b1;
                    end
                end
                PH_BODY:
                begin
                    len_next = len_dec;
                    // Stored CRC bytes, then covered bytes
                    if (kind_reg != KIND_INFO)
                    begin
                        if (pos_reg >= crc_at && pos_reg < crc_at + 6'd4)
                        begin
                            exp_next = exp_reg |
                                       ({24'd0, data_byte} << {pos_reg[1:0], 3'b000});
                        end
                        else if (pos_reg >= crc_at + 6'd4)
                        begin
                            run_next = crc_upd;
                        end
                    end
                    if (pos_reg < POS_CAP)
                    begin
                        pos_next = pos_reg + 6'd1;
                    end
                    if (body_last)
                    begin
                        emit = 1'b1;
                        if (kind_reg == KIND_INFO)
                        begin
                            res.status = ST_UNCHECKED;
                        end
                        else
                        begin
                            res.comp   = ~run_next;
                            res.stored = exp_next;
                            res.status = (~run_next == exp_next) ? ST_OK : ST_BAD;
                        end
                        pos_next   = 6'd0;
                        magic_next = 24'd0;
                    end
                    else if (end_of_file)
                    begin
                        emit = 1'b1;
                    end
                end
                PH_SKIP:
                begin
                    len_next = len_dec;
                    if (body_last)
                    begin
                        pos_next   = 6'd0;
                        magic_next = 24'd0;
                    end
                end
                PH_IGNORE:
                begin
                    pos_next = pos_reg;
                end
                default:
                begin
                    pos_next = 6'd0;
                end
            endcase

            // Last byte of the file: back to the reset state
            if (end_of_file)
            begin
                file_pos_next = 32'd0;
                pos_next      = 6'd0;
                len_next      = '0;
                kind_next     = KIND_HEADER;
                magic_next    = 24'd0;
                exp_next      = 32'd0;
                run_next      = CRC_INIT;
                start_next    = 32'd0;
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEAD;
            file_pos_reg <= 32'd0;
            pos_reg      <= 6'd0;
            len_reg      <= '0;
            kind_reg     <= KIND_HEADER;
            magic_reg    <= 24'd0;
            exp_reg      <= 32'd0;
            run_reg      <= CRC_INIT;
            start_reg    <= 32'd0;
        end
        else
        begin
            phase_reg    <= phase_next;
            file_pos_reg <= file_pos_next;
            pos_reg      <= pos_next;
            len_reg      <= len_next;
            kind_reg     <= kind_next;
            magic_reg    <= magic_next;
            exp_reg      <= exp_next;
            run_reg      <= run_next;
            start_reg    <= start_next;
        end
    end

endmodule

// ===== dv/tb_tagged_section_crc_verifier_core.sv =====
`timescale 1ns / 1ps

module tb_tagged_section_crc_verifier_core;
    import tsc_pkg::*;

    localparam int SIZE_BITS   = SIZE_BITS_DEF;
    localparam int RAND_BYTES  = 1350;
    localparam int HOLD_CYCLES = 60;
    localparam int STALL_LIMIT = 4000;

    typedef enum int {
        IDLE_NONE,
        IDLE_TX,
        IDLE_RX,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct {
        logic [7:0] b;
        logic       e;
        bit         fx;
        result_t    r;
    } stim_row_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic [7:0]  data_byte   = 8'h00;
    logic        end_of_file = 1'b0;
    logic        out_stall   = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [2:0]  section_kind;
    logic [2:0]  status;
    logic [31:0] section_start;
    logic [31:0] computed_crc;
    logic [31:0] stored_crc;
    logic        last_result;

    // Parser model state
    phase_t      prs_phase;
    kind_t       prs_kind;
    logic [31:0] prs_fpos;
    logic [31:0] prs_pos;
    logic [31:0] prs_len;
    logic [23:0] prs_shift;
    logic [31:0] prs_stored;
    logic [31:0] prs_crc;
    logic [31:0] prs_start;

    // Pending section reports, oldest first
    result_t     report_q[$];
    result_t     head_r;
    stim_row_t   stim_tab[$];
    logic [7:0]  file_q[$];

    int          tx_pct      = 0;
    int          rx_pct      = 0;
    bit          hold_req    = 1'b0;
    int          n_errors    = 0;
    int          n_bytes     = 0;
    int          n_files     = 0;
    int          rand_bytes  = 0;
    int          n_results   = 0;
    int          idle_cycles = 0;
    int          st_seen[6];

    tagged_section_crc_verifier_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .end_of_file   (end_of_file),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .section_kind  (section_kind),
        .status        (status),
        .section_start (section_start),
        .computed_crc  (computed_crc),
        .stored_crc    (stored_crc),
        .last_result   (last_result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Bytewise reflected CRC-32
    function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
        c = c ^ {24'h0, b};
        for (int i = 0; i < 8; i++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    function automatic result_t make_result(kind_t k, status_t s, logic [31:0] st,
                                            logic [31:0] comp, logic [31:0] stored,
                                            logic l);
        result_t r;
        r.kind   = k;
        r.status = s;
        r.start  = st;
        r.comp   = comp;
        r.stored = stored;
        r.last   = l;
        return r;
    endfunction

    function automatic void clear_parser();
        prs_phase  = PH_HEAD;
        prs_kind   = KIND_HEADER;
        prs_fpos   = '0;
        prs_pos    = '0;
        prs_len    = '0;
        prs_shift  = '0;
        prs_stored = '0;
        prs_crc    = CRC_INIT;
        prs_start  = '0;
    endfunction

    function automatic void open_section(kind_t k);
        prs_kind   = k;
        prs_phase  = PH_SIZE;
        prs_pos    = 32'd4;
        prs_len    = '0;
        prs_stored = '0;
        prs_crc    = CRC_INIT;
    endfunction

    function automatic void close_section();
        prs_phase = PH_WORD;
        prs_pos   = '0;
        prs_shift = '0;
    endfunction

    // Advance the parser by one byte; returns 1 when a section report is due
    function automatic bit parse_byte(input logic [7:0] b, input logic e, output result_t r);
        logic [31:0] here;
        logic [31:0] word;
        logic [31:0] size;
        logic [31:0] lim;
        logic [31:0] at;
        logic [31:0] p;
        logic [31:0] comp;
        logic [63:0] msk;
        bit          got;
        got  = 1'b0;
        r    = '0;
        here = prs_fpos;
        prs_fpos = prs_fpos + 32'd1;
        case (prs_phase)
            PH_HEAD, PH_WORD:
            begin
                if (prs_pos == 0)
                begin
                    prs_start = here;
                    prs_shift = '0;
                end
                if (prs_pos < 3)
                begin
                    prs_shift = {prs_shift[15:0], b};
                    prs_pos   = prs_pos + 32'd1;
                    if (e)
                    begin
                        got = 1'b1;
                        if (prs_phase == PH_HEAD)
                            r = make_result(KIND_HEADER, ST_TRUNC, prs_start, 0, 0, 1'b1);
                        else
                            r = make_result(KIND_UNKNOWN, ST_TRUNC, prs_start, 0, 0, 1'b1);
                    end
                end
                else
                begin
                    word = {prs_shift, b};
                    if (prs_phase == PH_HEAD)
                    begin
                        if (word == MAGIC_HEADER)
                            open_section(KIND_HEADER);
                        else
                        begin
                            got = 1'b1;
                            r = make_result(KIND_HEADER, ST_MAGIC, prs_start, 0, 0, e);
                            prs_phase = PH_IGNORE;
                        end
                    end
                    else
                    begin
                        case (word)
                            MAGIC_SOUND:  open_section(KIND_SOUND);
                            MAGIC_FRAMES: open_section(KIND_FRAMES);
                            MAGIC_INFO:   open_section(KIND_INFO);
                            MAGIC_THUMB:  open_section(KIND_THUMB);
                            default:
                            begin
                                got = 1'b1;
                                r = make_result(KIND_UNKNOWN, ST_UNCHECKED, prs_start, 0, 0, e);
                                close_section();
                            end
                        endcase
                    end
                    if (e && !got)
                    begin
                        got = 1'b1;
                        r = make_result(prs_kind, ST_TRUNC, prs_start, 0, 0, 1'b1);
                    end
                end
            end
            PH_SIZE:
            begin
                prs_len = prs_len | ({24'h0, b} << (8 * ((prs_pos - 4) & 3)));
                prs_pos = prs_pos + 32'd1;
                if (prs_pos >= 8)
                begin
                    msk  = (64'd1 << SIZE_BITS) - 64'd1;
                    size = prs_len & msk[31:0];
                    if (prs_kind == KIND_SOUND)
                        lim = {26'd0, SOUND_MIN};
                    else if (prs_kind == KIND_INFO)
                        lim = {26'd0, INFO_MIN};
                    else
                        lim = {26'd0, OTHER_MIN};
                    prs_len = size;
                    prs_pos = 32'd8;
                    if (size < lim)
                    begin
                        got = 1'b1;
                        r = make_result(prs_kind, ST_SMALL, prs_start, 0, 0, e);
                        if (size == 0)
                            close_section();
                        else
                            prs_phase = PH_SKIP;
                    end
                    else if (size == 0)
                    begin
                        got = 1'b1;
                        r = make_result(prs_kind, ST_UNCHECKED, prs_start, 0, 0, e);
                        close_section();
                    end
                    else
                    begin
                        prs_phase = PH_BODY;
                        if (e)
                        begin
                            got = 1'b1;
                            r = make_result(prs_kind, ST_TRUNC, prs_start, 0, 0, 1'b1);
                        end
                    end
                end
                else if (e)
                begin
                    got = 1'b1;
                    r = make_result(prs_kind, ST_TRUNC, prs_start, 0, 0, 1'b1);
                end
            end
            PH_BODY:
            begin
                at = (prs_kind == KIND_SOUND) ? {26'd0, SOUND_CRC_AT} : {26'd0, OTHER_CRC_AT};
                p  = prs_pos;
                prs_len = prs_len - 32'd1;
                if (prs_kind != KIND_INFO)
                begin
                    // stored CRC field, then the covered bytes
                    if (p >= at && p < at + 4)
                        prs_stored = prs_stored | ({24'h0, b} << (8 * ((p - at) & 3)));
                    else if (p >= at + 4)
                        prs_crc = crc_step(prs_crc, b);
                end
                if (p < {26'd0, POS_CAP})
                    prs_pos = p + 32'd1;
                if (prs_len == 0)
                begin
                    got = 1'b1;
                    if (prs_kind == KIND_INFO)
                        r = make_result(KIND_INFO, ST_UNCHECKED, prs_start, 0, 0, e);
                    else
                    begin
                        comp = ~prs_crc;
                        if (comp == prs_stored)
                            r = make_result(prs_kind, ST_OK, prs_start, comp, prs_stored, e);
                        else
                            r = make_result(prs_kind, ST_BAD, prs_start, comp, prs_stored, e);
                    end
                    close_section();
                end
                else if (e)
                begin
                    got = 1'b1;
                    r = make_result(prs_kind, ST_TRUNC, prs_start, 0, 0, 1'b1);
                end
            end
            PH_SKIP:
            begin
                prs_len = prs_len - 32'd1;
                if (prs_len == 0)
                    close_section();
            end
            default: ;
        endcase
        if (e)
            clear_parser();
        return got;
    endfunction

    // Directed table rows
    function automatic void row(logic [7:0] b, logic e);
        stim_row_t s;
        s.b  = b;
        s.e  = e;
        s.fx = 1'b0;
        s.r  = '0;
        stim_tab.push_back(s);
    endfunction

    function automatic void row_exp(logic [7:0] b, logic e, kind_t k, status_t st,
                                    logic [31:0] start, logic [31:0] stored);
        stim_row_t s;
        s.b  = b;
        s.e  = e;
        s.fx = 1'b1;
        s.r  = make_result(k, st, start, 32'h0, stored, e);
        stim_tab.push_back(s);
    endfunction

    // File builders
    function automatic void put_be32(logic [31:0] w);
        file_q.push_back(w[31:24]);
        file_q.push_back(w[23:16]);
        file_q.push_back(w[15:8]);
        file_q.push_back(w[7:0]);
    endfunction

    function automatic void put_le32(logic [31:0] w);
        file_q.push_back(w[7:0]);
        file_q.push_back(w[15:8]);
        file_q.push_back(w[23:16]);
        file_q.push_back(w[31:24]);
    endfunction

    function automatic void put_random(int n);
        for (int i = 0; i < n; i++)
            file_q.push_back(8'($urandom));
    endfunction

    // Checked section with a correct CRC most of the time
    function automatic void put_checked(logic [31:0] magic, int crc_at);
        logic [7:0]  cov[$];
        logic [31:0] c;
        int          ncov;
        ncov = ($urandom_range(9) == 0) ? int'($urandom_range(40)) : int'($urandom_range(6));
        c = CRC_INIT;
        for (int i = 0; i < ncov; i++)
        begin
            cov.push_back(8'($urandom));
            c = crc_step(c, cov[i]);
        end
        c = ~c;
        if ($urandom_range(3) == 0)
            c = c ^ (32'd1 << $urandom_range(31));
        put_be32(magic);
        put_le32(32'(crc_at - 8 + 4 + ncov));
        put_random(crc_at - 8);
        put_le32(c);
        foreach (cov[i])
            file_q.push_back(cov[i]);
    endfunction

    function automatic void put_small(logic [31:0] magic, logic [5:0] min);
        int size;
        size = int'($urandom_range({26'd0, min} - 1));
        put_be32(magic);
        put_le32(32'(size));
        put_random(size);
    endfunction

    function automatic void build_file();
        int          sel;
        int          nsec;
        int          cut;
        bit          stop;
        logic [31:0] w;
        file_q.delete();
        stop = 1'b0;
        sel  = int'($urandom_range(99));
        if (sel < 8)
        begin
            // wrong file magic, then bytes that are ignored
            w = $urandom;
            if ($urandom_range(1) == 0)
                w[31:24] = 8'h4B;
            if (w == MAGIC_HEADER)
                w = ~w;
            put_be32(w);
            put_random(int'($urandom_range(5)));
        end
        else if (sel < 14)
        begin
            // valid magic followed by garbage
            put_be32(MAGIC_HEADER);
            put_random(int'($urandom_range(36, 4)));
        end
        else
        begin
            if ($urandom_range(9) == 0)
                put_small(MAGIC_HEADER, OTHER_MIN);
            else
                put_checked(MAGIC_HEADER, int'(OTHER_CRC_AT));
            nsec = int'($urandom_range(5));
            for (int i = 0; i < nsec && !stop; i++)
            begin
                case ($urandom_range(9))
                    0, 1: put_checked(MAGIC_SOUND, int'(SOUND_CRC_AT));
                    2, 3: put_checked(MAGIC_FRAMES, int'(OTHER_CRC_AT));
                    4, 9: put_checked(MAGIC_THUMB, int'(OTHER_CRC_AT));
                    5:
                    begin
                        w = 32'($urandom_range(16));
                        put_be32(MAGIC_INFO);
                        put_le32(w);
                        put_random(int'(w));
                    end
                    6:
                    begin
                        w = $urandom;
                        if ($urandom_range(1) == 0)
                            w[31:24] = 8'h4B;
                        if (w == MAGIC_SOUND || w == MAGIC_FRAMES || w == MAGIC_INFO ||
                            w == MAGIC_THUMB)
                            w[0] = ~w[0];
                        put_be32(w);
                    end
                    7:
                    begin
                        case ($urandom_range(2))
                            0: put_small(MAGIC_SOUND, SOUND_MIN);
                            1: put_small(MAGIC_FRAMES, OTHER_MIN);
                            default: put_small(MAGIC_THUMB, OTHER_MIN);
                        endcase
                    end
                    default:
                    begin
                        // huge size, the file ends inside the body
                        case ($urandom_range(3))
                            0: put_be32(MAGIC_SOUND);
                            1: put_be32(MAGIC_FRAMES);
                            2: put_be32(MAGIC_INFO);
                            default: put_be32(MAGIC_THUMB);
                        endcase
                        put_le32($urandom | 32'h0001_0000);
                        put_random(int'($urandom_range(20, 2)));
                        stop = 1'b1;
                    end
                endcase
            end
        end
        // cut the file short now and then
        if ($urandom_range(4) == 0 && file_q.size() > 1)
        begin
            cut = int'($urandom_range(file_q.size() - 1, 1));
            while (file_q.size() > cut)
                void'(file_q.pop_back());
        end
    endfunction

    function automatic void set_idle(idle_mode_t m);
        case (m)
            IDLE_NONE:
            begin
                tx_pct = 0;
                rx_pct = 0;
            end
            IDLE_TX:
            begin
                tx_pct = 45;
                rx_pct = 0;
            end
            IDLE_RX:
            begin
                tx_pct = 0;
                rx_pct = 45;
            end
            default:
            begin
                tx_pct = 31;
                rx_pct = 31;
            end
        endcase
    endfunction

    // Offer one byte, wait for the transfer, then queue its report
    task automatic xfer_byte(input logic [7:0] b, input logic e, input bit fx,
                             input result_t fr);
        result_t pr;
        bit      got;
        while ($urandom_range(99) < tx_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        data_byte   <= b;
        end_of_file <= e;
        do
            @(posedge clk);
        while (in_stall);
        got = parse_byte(b, e, pr);
        if (fx)
            report_q.push_back(fr);
        else if (got)
            report_q.push_back(pr);
        n_bytes++;
    endtask

    // Receiver stall, with a long counted hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= ($urandom_range(99) < rx_pct);
        end
    end

    // Compare each result transfer with the oldest pending report
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (report_q.size() == 0)
            begin
                $error("unexpected result: kind %0d status %0d start %0h",
                       section_kind, status, section_start);
                n_errors++;
            end
            else
            begin
                head_r = report_q.pop_front();
                if (section_kind !== head_r.kind)
                begin
                    $error("section_kind: expected %0d, got %0d", head_r.kind, section_kind);
                    n_errors++;
                end
                if (status !== head_r.status)
                begin
                    $error("status: expected %0d, got %0d", head_r.status, status);
                    n_errors++;
                end
                if (section_start !== head_r.start)
                begin
                    $error("section_start: expected %0h, got %0h", head_r.start, section_start);
                    n_errors++;
                end
                if (computed_crc !== head_r.comp)
                begin
                    $error("computed_crc: expected %0h, got %0h", head_r.comp, computed_crc);
                    n_errors++;
                end
                if (stored_crc !== head_r.stored)
                begin
                    $error("stored_crc: expected %0h, got %0h", head_r.stored, stored_crc);
                    n_errors++;
                end
                if (last_result !== head_r.last)
                begin
                    $error("last_result: expected %0d, got %0d", head_r.last, last_result);
                    n_errors++;
                end
                n_results++;
                st_seen[head_r.status]++;
            end
        end
    end

    // Watchdog on cycles without any transfer
    initial
    begin
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        clear_parser();
        foreach (st_seen[i])
            st_seen[i] = 0;

        // wrong file magic of all ones, then an ignored end-of-file byte
        row(8'hFF, 1'b0);
        row(8'hFF, 1'b0);
        row(8'hFF, 1'b0);
        row_exp(8'hFF, 1'b0, KIND_HEADER, ST_MAGIC, 32'h0, 32'h0);
        row(8'h00, 1'b1);
        // file ends inside the header magic
        row_exp(8'h4B, 1'b1, KIND_HEADER, ST_TRUNC, 32'h0, 32'h0);
        // header with nothing covered after the CRC field, stored CRC all ones
        row(8'h4B, 1'b0);
        row(8'h46, 1'b0);
        row(8'h48, 1'b0);
        row(8'h14, 1'b0);
        row(8'h04, 1'b0);
        row(8'h00, 1'b0);
        row(8'h00, 1'b0);
        row(8'h00, 1'b0);
        row(8'hFF, 1'b0);
        row(8'hFF, 1'b0);
        row(8'hFF, 1'b0);
        row_exp(8'hFF, 1'b0, KIND_HEADER, ST_BAD, 32'h0, 32'hFFFF_FFFF);
        // sound section of size zero, too small, on the last byte
        row(8'h4B, 1'b0);
        row(8'h53, 1'b0);
        row(8'h4E, 1'b0);
        row(8'h01, 1'b0);
        row(8'h00, 1'b0);
        row(8'h00, 1'b0);
        row(8'h00, 1'b0);
        row_exp(8'h00, 1'b1, KIND_SOUND, ST_SMALL, 32'd12, 32'h0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idle(IDLE_NONE);
        foreach (stim_tab[i])
            xfer_byte(stim_tab[i].b, stim_tab[i].e, stim_tab[i].fx, stim_tab[i].r);

        // random files, idling mode stepping through the run
        while (rand_bytes < RAND_BYTES)
        begin
            build_file();
            n_files++;
            for (int i = 0; i < file_q.size(); i++)
            begin
                if (rand_bytes * 4 / RAND_BYTES >= 3)
                    set_idle(IDLE_BOTH);
                else
                    set_idle(idle_mode_t'(rand_bytes * 4 / RAND_BYTES));
                if (rand_bytes == 150 || rand_bytes == 1200)
                    hold_req = 1'b1;
                xfer_byte(file_q[i], (i == file_q.size() - 1), 1'b0, '0);
                rand_bytes++;
            end
        end
        in_valid <= 1'b0;

        while (report_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d bytes (%0d in %0d random files), checked %0d section reports",
                 n_bytes, rand_bytes, n_files, n_results);
        $display("ok %0d, mismatch %0d, unchecked %0d, bad magic %0d, truncated %0d, small %0d",
                 st_seen[ST_OK], st_seen[ST_BAD], st_seen[ST_UNCHECKED], st_seen[ST_MAGIC],
                 st_seen[ST_TRUNC], st_seen[ST_SMALL]);
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
